@@ rtl/rc4_pkg.sv @@
// rc4_pkg: shared types and constants for the rc4 stream cipher
// holds byte widths, key store limits, item codes and controller states
// no dependencies
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int BYTE_W        = 8;
   localparam int PERM_DEPTH    = 256;
   localparam int MAX_KEY_BYTES = 256;
   localparam int KEY_CNT_W     = 9;

   localparam logic [BYTE_W-1:0]    LAST_INDEX = BYTE_W'(PERM_DEPTH - 1);
   localparam logic [KEY_CNT_W-1:0] KEY_MAX    = KEY_CNT_W'(MAX_KEY_BYTES);

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_NO_KEY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_J,
      ST_SWAP_I,
      ST_SWAP_J,
      ST_FILL,
      ST_KSA_ACC,
      ST_KSA_W1,
      ST_KSA_W2
   } state_type;

endpackage

@@ rtl/rc4_stream_cipher_top.sv @@
// rc4_stream_cipher_top: rc4 key store, key schedule and keystream generator
// depends on rc4_pkg and rc4_ram (permutation ram and key ram)
//
// data item: ST_RD_J, ST_SWAP_I, ST_SWAP_J; unless output stalls, ST_SWAP_J registers result and takes next item
// data item before a key: error result valid in the cycle after accept
// last key item or last data item: key schedule, ST_FILL of 256 entries, then ACC, W1, W2 per swap step
// reset clears control, key count and indices; ram contents stay undefined until written
`timescale 1ns / 1ps

module rc4_stream_cipher_top
   import rc4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic [BYTE_W-1:0] req_value,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_data_out,
   output logic              rsp_end_of_message,
   output logic              rsp_status
);

   state_type state_ff, state_in;

   logic                 key_ready_ff, key_ready_in;
   logic [KEY_CNT_W-1:0] key_count_ff, key_count_in;
   logic [BYTE_W-1:0]    i_ff, i_in;
   logic [BYTE_W-1:0]    j_ff, j_in;
   logic [BYTE_W-1:0]    n_ff, n_in;
   logic [BYTE_W-1:0]    acc_ff, acc_in;
   logic [BYTE_W-1:0]    kpos_ff, kpos_in;
   logic [BYTE_W-1:0]    sn_ff, sn_in;
   logic [BYTE_W-1:0]    si_ff, si_in;
   logic [BYTE_W-1:0]    t_ff, t_in;
   logic [BYTE_W-1:0]    value_ff, value_in;
   logic                 last_ff, last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_eom_ff, rsp_eom_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              p_we;
   logic [BYTE_W-1:0] p_waddr, p_wdata, p_raddr, p_rdata;
   logic              k_we;
   logic [BYTE_W-1:0] k_waddr, k_wdata, k_raddr, k_rdata;

   logic                 slot_free;
   logic                 take_ok;
   logic                 take;
   logic [KEY_CNT_W-1:0] cnt_eff;
   logic                 key_store_en;
   logic [KEY_CNT_W-1:0] kpos_next;
   logic [BYTE_W-1:0]    keystream;
   state_type            item_next;

   rc4_ram #(.ADDR_W(BYTE_W), .DATA_W(BYTE_W)) u_perm_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (p_waddr),
      .wdata (p_wdata),
      .raddr (p_raddr),
      .rdata (p_rdata)
   );

   rc4_ram #(.ADDR_W(BYTE_W), .DATA_W(BYTE_W)) u_key_ram (
      .clock (clock),
      .we    (k_we),
      .waddr (k_waddr),
      .wdata (k_wdata),
      .raddr (k_raddr),
      .rdata (k_rdata)
   );

   // handshake
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign take_ok   = ((state_ff == ST_IDLE) && slot_free) ||
                      ((state_ff == ST_SWAP_J) && slot_free && !last_ff);
   assign req_stall = !take_ok;
   assign take      = req_valid && take_ok;

   assign cnt_eff      = key_ready_ff ? '0 : key_count_ff;
   assign key_store_en = cnt_eff < KEY_MAX;
   assign kpos_next    = {1'b0, kpos_ff} + KEY_CNT_W'(1);
   // forward si when t hits j, since the swap write of j is not yet in the ram
   assign keystream    = (t_ff == j_ff) ? si_ff : p_rdata;

   // where an accepted item leads
   always_comb begin
      if (req_op == OP_KEY) begin
         item_next = req_last ? ST_FILL : ST_IDLE;
      end else begin
         item_next = key_ready_ff ? ST_RD_J : ST_IDLE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               state_in = item_next;
            end
         end
         ST_RD_J:   state_in = ST_SWAP_I;
         ST_SWAP_I: state_in = ST_SWAP_J;
         ST_SWAP_J: begin
            if (slot_free) begin
               if (last_ff) begin
                  state_in = ST_FILL;
               end else if (take) begin
                  state_in = item_next;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FILL: begin
            if (n_ff == LAST_INDEX) begin
               state_in = ST_KSA_ACC;
            end
         end
         ST_KSA_ACC: state_in = ST_KSA_W1;
         ST_KSA_W1:  state_in = ST_KSA_W2;
         ST_KSA_W2: begin
            state_in = (n_ff == LAST_INDEX) ? ST_IDLE : ST_KSA_ACC;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      key_ready_in = key_ready_ff;
      key_count_in = key_count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      kpos_in      = kpos_ff;
      sn_in        = sn_ff;
      si_in        = si_ff;
      t_in         = t_ff;
      value_in     = value_ff;
      last_in      = last_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_eom_in    = rsp_eom_ff;
      rsp_status_in = rsp_status_ff;

      p_we    = 1'b0;
      p_waddr = '0;
      p_wdata = '0;
      p_raddr = t_ff;
      k_we    = 1'b0;
      k_waddr = cnt_eff[BYTE_W-1:0];
      k_wdata = req_value;
      k_raddr = kpos_ff;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_RD_J: begin
            si_in   = p_rdata;
            j_in    = j_ff + p_rdata;
            p_raddr = j_ff + p_rdata;
         end
         ST_SWAP_I: begin
            p_we    = 1'b1;
            p_waddr = i_ff;
            p_wdata = p_rdata;
            p_raddr = si_ff + p_rdata;
            t_in    = si_ff + p_rdata;
         end
         ST_SWAP_J: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = si_ff;
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = value_ff ^ keystream;
               rsp_eom_in    = last_ff;
               rsp_status_in = STATUS_OK;
               if (last_ff) begin
                  n_in   = '0;
                  acc_in = '0;
                  i_in   = '0;
                  j_in   = '0;
               end
            end
         end
         ST_FILL: begin
            p_we    = 1'b1;
            p_waddr = n_ff;
            p_wdata = n_ff;
            n_in    = n_ff + BYTE_W'(1);
            if (n_ff == LAST_INDEX) begin
               p_raddr = '0;
               k_raddr = '0;
               kpos_in = '0;
            end
         end
         ST_KSA_ACC: begin
            sn_in   = p_rdata;
            acc_in  = acc_ff + p_rdata + k_rdata;
            p_raddr = acc_ff + p_rdata + k_rdata;
            kpos_in = (kpos_next >= key_count_ff) ? '0 : kpos_next[BYTE_W-1:0];
         end
         ST_KSA_W1: begin
            p_we    = 1'b1;
            p_waddr = n_ff;
            p_wdata = p_rdata;
         end
         ST_KSA_W2: begin
            p_we    = 1'b1;
            p_waddr = acc_ff;
            p_wdata = sn_ff;
            n_in    = n_ff + BYTE_W'(1);
            p_raddr = n_ff + BYTE_W'(1);
            k_raddr = kpos_ff;
         end
         default: begin
         end
      endcase

      if (take) begin
         if (req_op == OP_KEY) begin
            k_we         = key_store_en;
            key_count_in = key_store_en ? (cnt_eff + KEY_CNT_W'(1)) : cnt_eff;
            key_ready_in = req_last;
            if (req_last) begin
               n_in   = '0;
               acc_in = '0;
               i_in   = '0;
               j_in   = '0;
            end
         end else if (key_ready_ff) begin
            p_raddr  = i_ff + BYTE_W'(1);
            i_in     = i_ff + BYTE_W'(1);
            value_in = req_value;
            last_in  = req_last;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = '0;
            rsp_eom_in    = req_last;
            rsp_status_in = STATUS_NO_KEY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_ready_ff <= 1'b0;
         key_count_ff <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         acc_ff       <= '0;
         kpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_ready_ff <= key_ready_in;
         key_count_ff <= key_count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         acc_ff       <= acc_in;
         kpos_ff      <= kpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sn_ff         <= sn_in;
      si_ff         <= si_in;
      t_ff          <= t_in;
      value_ff      <= value_in;
      last_ff       <= last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_eom_ff    <= rsp_eom_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_end_of_message = rsp_eom_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

@@ rtl/rc4_ram.sv @@
// rc4_ram: generic synchronous ram, one write port and one read port
// read data registered, write-first when both ports hit the same entry
// no dependencies
`timescale 1ns / 1ps

module rc4_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (we && (waddr == raddr)) begin
         rdata <= wdata;
      end else begin
         rdata <= mem[raddr];
      end
   end

endmodule
